### design/time_bin_histogram_defines.svh
// ----------------------------------------------------------------------------
// time bin histogram assertion macros
// shared concurrent assertion forms, clocked on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef TIME_BIN_HISTOGRAM_DEFINES_SVH
`define TIME_BIN_HISTOGRAM_DEFINES_SVH

// same-cycle implication
`define TBH_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("time_bin_histogram: same-cycle check failed");

// next-cycle implication
`define TBH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("time_bin_histogram: next-cycle check failed");

`endif

### design/tbh_pkg.sv
// ----------------------------------------------------------------------------
// tbh_pkg
// shared types, sizes and helpers of the time bin histogram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbh_pkg;

   localparam int TIME_W      = 20;
   localparam int EVT_W       = 16;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int KIND_W      = 2;
   localparam int BIN_COUNT   = 4096;
   localparam int COUNT_WIDTH = 32;
   localparam int ADDR_W      = $clog2(BIN_COUNT);
   localparam int SPAN_W      = ADDR_W + 1;
   localparam int ADD_W       = ((COUNT_WIDTH > EVT_W) ? COUNT_WIDTH : EVT_W) + 1;

   localparam logic [TIME_W:0]        BIN_LIMIT = (TIME_W + 1)'(BIN_COUNT);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [VALUE_W-1:0]     VALUE_MAX = {VALUE_W{1'b1}};

   localparam logic [STATUS_W-1:0] STATUS_DONE    = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_START   = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = STATUS_W'(2);

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD  = 2'd0,
      KIND_READ = 2'd1,
      KIND_SUM  = 2'd2,
      KIND_NOP  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_ACCESS,
      S_SUM
   } fsm_state_type;

   // window decode of one request
   typedef struct packed {
      logic              start_evt;
      logic              in_win;
      logic [ADDR_W-1:0] slot;
      logic [ADDR_W-1:0] lo;
      logic [SPAN_W-1:0] hi;
      logic              empty;
   } dec_type;

   // clamp a bin count to the result width
   function automatic logic [VALUE_W-1:0] sat_value(input logic [COUNT_WIDTH-1:0] c);
      logic [63:0] wide;
      wide = 64'(c);
      return (wide > 64'(VALUE_MAX)) ? VALUE_MAX : wide[VALUE_W-1:0];
   endfunction

endpackage

`default_nettype wire

### design/tbh_ram.sv
// ----------------------------------------------------------------------------
// tbh_ram
// simple dual-port memory, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbh_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/tbh_decode.sv
// ----------------------------------------------------------------------------
// tbh_decode
// maps request times onto histogram entries and clips sum ranges
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbh_decode import tbh_pkg::*; (
   input  wire logic [TIME_W-1:0] time_bin,
   input  wire logic [TIME_W-1:0] end_bin,
   input  wire logic [TIME_W-1:0] time_zero,
   output dec_type                dec
);

   logic [TIME_W:0]   diff;
   logic [TIME_W-1:0] lo_full;
   logic [TIME_W-1:0] hi_full;
   logic [SPAN_W-1:0] hi_clip;

   always_comb begin
      diff    = {1'b0, time_bin} - {1'b0, time_zero};
      lo_full = (time_bin > time_zero) ? (time_bin - time_zero) : '0;
      hi_full = (end_bin > time_zero) ? (end_bin - time_zero) : '0;
      // end clipped down to the window end
      if ({1'b0, hi_full} > BIN_LIMIT) begin
         hi_clip = SPAN_W'(BIN_COUNT);
      end else begin
         hi_clip = hi_full[SPAN_W-1:0];
      end

      dec.start_evt = (time_bin == '0);
      dec.in_win    = !diff[TIME_W] && (diff < BIN_LIMIT);
      dec.slot      = diff[ADDR_W-1:0];
      dec.lo        = lo_full[ADDR_W-1:0];
      dec.hi        = hi_clip;
      dec.empty     = (lo_full >= TIME_W'(hi_clip));
   end

endmodule

`default_nettype wire

### design/time_bin_histogram.sv
// ----------------------------------------------------------------------------
// time_bin_histogram
// time-of-flight histogram over a window of bins held in one block memory
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   req_      in    req_valid/req_ready    kind, time_bin, event_count, end_bin
//   rsp_      out   rsp_valid/rsp_ready    value, status
//   csr_      in    csr_valid/csr_ready    time_zero
//
// - one request at a time; the bin memory has one read and one write port
// - add and in-window read: memory read, then modify/write back
// - requests with no memory access load their result as they are taken
// - sum: reads from the clipped start to below the clipped end, one bin read
//   per cycle, stopping early once the total saturates
// - after reset a clearing pass writes zero to every bin, during which
//   req_ready is low; csr writes are taken throughout
// - a result waits in the output register; the next request is taken in
//   the cycle that result leaves
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "time_bin_histogram_defines.svh"

module time_bin_histogram import tbh_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [TIME_W-1:0]   req_time_bin,
   input  wire logic [EVT_W-1:0]    req_event_count,
   input  wire logic [TIME_W-1:0]   req_end_bin,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [VALUE_W-1:0]       rsp_value,
   output logic [STATUS_W-1:0]      rsp_status,

   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [TIME_W-1:0]   csr_time_zero
);

   // control registers
   fsm_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [TIME_W-1:0] time_zero_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // request payload held while the memory works
   kind_type          op_ff, op_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [EVT_W-1:0]  evt_ff, evt_in;
   logic [SPAN_W-1:0] hi_ff, hi_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // decode and handshake
   dec_type  dec;
   kind_type kind_in;
   logic     out_free;
   logic     accept;
   logic     go_access;
   logic     go_sum;
   logic     clr_last;

   // memory ports
   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [COUNT_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [COUNT_WIDTH-1:0] mem_rd_data;

   // arithmetic on the read data
   logic [ADD_W-1:0]       add_sum;
   logic [COUNT_WIDTH-1:0] add_result;
   logic [VALUE_W:0]       sum_total;
   logic                   sum_sat;
   logic                   sum_last;
   logic                   sum_done;

   // result load
   logic                res_load;
   logic [VALUE_W-1:0]  res_value;
   logic [STATUS_W-1:0] res_status;

   tbh_decode u_decode (
      .time_bin  (req_time_bin),
      .end_bin   (req_end_bin),
      .time_zero (time_zero_ff),
      .dec       (dec)
   );

   tbh_ram #(
      .DEPTH (BIN_COUNT),
      .WIDTH (COUNT_WIDTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // configuration register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_zero_ff <= '0;
      end else if (csr_valid) begin
         time_zero_ff <= csr_time_zero;
      end
   end

   // a request is taken only in idle and only when the output slot frees up
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      kind_in   = kind_type'(req_kind);
      go_access = ((kind_in == KIND_ADD) && !dec.start_evt && dec.in_win) ||
                  ((kind_in == KIND_READ) && dec.in_win);
      go_sum    = (kind_in == KIND_SUM) && !dec.empty;
      clr_last  = (clr_addr_ff == ADDR_W'(BIN_COUNT - 1));
   end

   // saturating add of events to the bin just read
   always_comb begin
      add_sum    = ADD_W'(mem_rd_data) + ADD_W'(evt_ff);
      add_result = (add_sum > ADD_W'(COUNT_MAX)) ? COUNT_MAX : add_sum[COUNT_WIDTH-1:0];
   end

   // running range total; stops at the last bin or once it saturates
   always_comb begin
      sum_total = {1'b0, acc_ff} + {1'b0, sat_value(mem_rd_data)};
      sum_sat   = (sum_total >= {1'b0, VALUE_MAX});
      sum_last  = ((SPAN_W'(slot_ff) + SPAN_W'(1)) == hi_ff);
      sum_done  = sum_sat || sum_last;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && go_access) begin
               state_in = S_ACCESS;
            end else if (accept && go_sum) begin
               state_in = S_SUM;
            end
         end
         S_ACCESS: begin
            state_in = S_IDLE;
         end
         S_SUM: begin
            if (sum_done) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // state outputs: memory control and result load
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_ff;
      mem_wr_data = add_result;
      mem_rd_en   = 1'b0;
      mem_rd_addr = slot_ff;
      res_load    = 1'b0;
      res_value   = '0;
      res_status  = STATUS_DONE;
      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
         end
         S_IDLE: begin
            if (accept) begin
               if (go_access) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = dec.slot;
               end else if (go_sum) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = dec.lo;
               end else begin
                  // answered at once: start event, dropped add, miss, empty range or nop
                  res_load = 1'b1;
                  if ((kind_in == KIND_ADD) && dec.start_evt) begin
                     res_status = STATUS_START;
                  end else if (kind_in == KIND_ADD) begin
                     res_status = STATUS_OUTSIDE;
                  end
               end
            end
         end
         S_ACCESS: begin
            res_load = 1'b1;
            if (op_ff == KIND_ADD) begin
               mem_wr_en = 1'b1;
            end else begin
               res_value = sat_value(mem_rd_data);
            end
         end
         S_SUM: begin
            if (sum_done) begin
               res_load  = 1'b1;
               res_value = sum_sat ? VALUE_MAX : sum_total[VALUE_W-1:0];
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_ff + ADDR_W'(1);
            end
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      evt_in        = evt_ff;
      hi_in         = hi_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (state_ff == S_CLEAR) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end

      if (accept) begin
         op_in   = kind_in;
         evt_in  = req_event_count;
         hi_in   = dec.hi;
         acc_in  = '0;
         slot_in = go_sum ? dec.lo : dec.slot;
      end else if ((state_ff == S_SUM) && !sum_done) begin
         acc_in  = sum_total[VALUE_W-1:0];
         slot_in = slot_ff + ADDR_W'(1);
      end

      if (res_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value;
         rsp_status_in = res_status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      evt_ff        <= evt_in;
      hi_ff         <= hi_in;
      acc_ff        <= acc_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // no request while bins are being cleared
   `TBH_ASSERT_SAME(a_clear_blocks_req, state_ff == S_CLEAR, !req_ready)
   // a new result never overwrites one that is still waiting
   `TBH_ASSERT_SAME(a_load_into_free, res_load, out_free)
   // range walk stays below the clipped end
   `TBH_ASSERT_SAME(a_sum_in_range, state_ff == S_SUM, SPAN_W'(slot_ff) < hi_ff)
   // an access is always followed by idle, never another access
   `TBH_ASSERT_NEXT(a_access_one_cycle, state_ff == S_ACCESS, state_ff == S_IDLE)

endmodule

`default_nettype wire
